### rtl/core/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, constants and helpers for the text console cursor engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int TAB_WIDTH = 8;
  localparam int CNT_W     = $clog2(TAB_WIDTH + 1);
  localparam int CFG_IDX_W = 8;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = CFG_IDX_W'(1);

  localparam logic [7:0] COLUMNS_RESET = 8'd170;
  localparam logic [7:0] ROWS_RESET    = 8'd48;

  typedef enum logic [1:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_TAB
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  glyph;
    logic [31:0] fg;
    logic [31:0] bg;
  } op_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
  } cursor_t;

  // spaces a tab writes, indexed by the column it starts from
  typedef logic [CNT_W-1:0] tab_lut_t [256];

  function automatic tab_lut_t build_tab_lut();
    tab_lut_t t;
    int       ph;
    ph = 0;
    for (int i = 0; i < 256; i++) begin
      t[i] = CNT_W'(TAB_WIDTH - ph);
      ph = (ph == TAB_WIDTH - 1) ? 0 : ph + 1;
    end
    return t;
  endfunction

  localparam tab_lut_t TAB_LUT = build_tab_lut();

  // column overflow starts a new row, then row overflow wraps to row 0
  function automatic cursor_t wrap_cursor(input logic [8:0] col, input logic [8:0] row,
                                          input logic [7:0] columns,
                                          input logic [7:0] rows);
    cursor_t    c;
    logic       col_over;
    logic [9:0] row_w;
    col_over = (col >= {1'b0, columns});
    row_w    = {1'b0, row} + 10'(col_over);
    c.col    = col_over ? 8'd0 : col[7:0];
    c.row    = (row_w >= {2'b0, rows}) ? 8'd0 : row_w[7:0];
    return c;
  endfunction

endpackage

### rtl/core/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Keeps a column/row cursor on a character grid and turns characters into
// character cell writes, handling newline, backspace and tab.
// ----------------------------------------------------------------------------
//  channel   | direction | transaction
//  s_axis    | in        | one character with its colors
//  m_axis    | out       | one cell write, tlast on the final write of a character
//  cfg       | in        | register write: 0 columns, 1 rows
//
//  a printable character or backspace gives one cell write in the cursor engine;
//  a tab gives one cell write per space (up to TAB_WIDTH), paced by the single
//  cursor update per cycle while the output is not stalled; a newline gives none.
//  a character is registered in tcc_front, queued in tcc_queue and registered again at m_axis.
//  rst is synchronous and clears the cursor to 0,0 and the geometry to 170x48.
//  a stalled output holds the engine (not a newline) while the queue takes input until it is full.
// ----------------------------------------------------------------------------
module text_console_cursor_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [71:0]                   s_axis_tdata,   // char_code, text_fg, text_bg
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // cell_column, cell_row, glyph_code, cell_fg, cell_bg
  output logic [87:0]                   m_axis_tdata,
  output logic                          m_axis_tlast,   // last_of_run
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  logic         f_valid;
  logic         f_ready;
  tcc_pkg::op_t f_op;
  logic         q_valid;
  logic         q_ready;
  tcc_pkg::op_t q_op;

  assign cfg_ready = 1'b1;

  tcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  tcc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  tcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op        (q_op),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

### rtl/core/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front
// Input stage: registers each character and sorts it into an operation.
// ----------------------------------------------------------------------------
module tcc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [71:0]      in_data,
  output logic             op_valid,
  input  logic             op_ready,
  output tcc_pkg::op_t     op
);

  logic         hold_valid;
  tcc_pkg::op_t hold_op;
  tcc_pkg::op_t op_in;
  logic [7:0]   ch;

  assign in_ready = !hold_valid || op_ready;
  assign op_valid = hold_valid;
  assign op       = hold_op;
  assign ch       = in_data[7:0];

  always_comb begin
    op_in.fg    = in_data[39:8];
    op_in.bg    = in_data[71:40];
    op_in.glyph = tcc_pkg::CH_SPACE;
    case (ch)
      tcc_pkg::CH_NEWLINE:   op_in.kind = tcc_pkg::OP_NEWLINE;
      tcc_pkg::CH_BACKSPACE: op_in.kind = tcc_pkg::OP_BACKSPACE;
      tcc_pkg::CH_TAB:       op_in.kind = tcc_pkg::OP_TAB;
      default: begin
        op_in.kind  = tcc_pkg::OP_PRINT;
        op_in.glyph = ch;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (op_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_op <= op_in;
    end
  end

endmodule

### rtl/core/tcc_queue.sv
// ----------------------------------------------------------------------------
// tcc_queue
// Two-entry operation queue between the input stage and the cursor engine.
// ----------------------------------------------------------------------------
module tcc_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  tcc_pkg::op_t push_op,
  output logic         pop_valid,
  input  logic         pop_ready,
  output tcc_pkg::op_t pop_op
);

  tcc_pkg::op_t entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_op     = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_op;
    end
  end

endmodule

### rtl/core/tcc_back.sv
// ----------------------------------------------------------------------------
// tcc_back
// Cursor engine: holds geometry and cursor, executes operations and drives
// the registered cell write output.
// ----------------------------------------------------------------------------
module tcc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           op_valid,
  output logic                           op_ready,
  input  tcc_pkg::op_t                   op,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [87:0]                    out_data,
  output logic                           out_last
);

  logic [7:0]                columns;
  logic [7:0]                rows;
  tcc_pkg::cursor_t          cursor;
  tcc_pkg::cursor_t          cursor_next;
  tcc_pkg::cursor_t          pos_bs;
  tcc_pkg::cursor_t          emit_pos;
  logic                      tab_active;
  logic                      tab_active_next;
  logic [tcc_pkg::CNT_W-1:0] tab_left;
  logic [tcc_pkg::CNT_W-1:0] tab_left_next;
  logic [tcc_pkg::CNT_W-1:0] tab_remain;
  logic                      out_free;
  logic                      emit;
  logic                      emit_last;

  logic [7:0]                cell_column;
  logic [7:0]                cell_row;
  logic [7:0]                glyph_code;
  logic [31:0]               cell_fg;
  logic [31:0]               cell_bg;

  assign out_free   = !out_valid || out_ready;
  assign tab_remain = tab_active ? tab_left : tcc_pkg::TAB_LUT[cursor.col];
  assign out_data   = {cell_bg, cell_fg, glyph_code, cell_row, cell_column};

  // backspace steps back, wrapping to the last column and last row
  always_comb begin
    if (cursor.col == 8'd0) begin
      pos_bs.col = columns - 8'd1;
      pos_bs.row = (cursor.row == 8'd0) ? (rows - 8'd1) : (cursor.row - 8'd1);
    end else begin
      pos_bs.col = cursor.col - 8'd1;
      pos_bs.row = cursor.row;
    end
  end

  always_comb begin
    cursor_next     = cursor;
    tab_active_next = tab_active;
    tab_left_next   = tab_left;
    op_ready        = 1'b0;
    emit            = 1'b0;
    emit_last       = 1'b1;
    emit_pos        = cursor;
    if (op_valid) begin
      case (op.kind)
        tcc_pkg::OP_NEWLINE: begin
          op_ready    = 1'b1;
          cursor_next = tcc_pkg::wrap_cursor(9'd0, {1'b0, cursor.row} + 9'd1, columns, rows);
        end
        tcc_pkg::OP_BACKSPACE: begin
          if (out_free) begin
            op_ready    = 1'b1;
            emit        = 1'b1;
            emit_pos    = pos_bs;
            cursor_next = tcc_pkg::wrap_cursor({1'b0, pos_bs.col}, {1'b0, pos_bs.row},
                                               columns, rows);
          end
        end
        tcc_pkg::OP_TAB: begin
          if (out_free) begin
            emit        = 1'b1;
            emit_last   = (tab_remain == tcc_pkg::CNT_W'(1));
            cursor_next = tcc_pkg::wrap_cursor({1'b0, cursor.col} + 9'd1, {1'b0, cursor.row},
                                               columns, rows);
            if (emit_last) begin
              op_ready        = 1'b1;
              tab_active_next = 1'b0;
            end else begin
              tab_active_next = 1'b1;
              tab_left_next   = tab_remain - tcc_pkg::CNT_W'(1);
            end
          end
        end
        default: begin
          if (out_free) begin
            op_ready    = 1'b1;
            emit        = 1'b1;
            cursor_next = tcc_pkg::wrap_cursor({1'b0, cursor.col} + 9'd1, {1'b0, cursor.row},
                                               columns, rows);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns    <= tcc_pkg::COLUMNS_RESET;
      rows       <= tcc_pkg::ROWS_RESET;
      cursor     <= '0;
      tab_active <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tcc_pkg::REG_COLUMNS: columns <= cfg_data;
          tcc_pkg::REG_ROWS:    rows    <= cfg_data;
          default: ;
        endcase
      end
      cursor     <= cursor_next;
      tab_active <= tab_active_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tab_left <= tab_left_next;
    if (emit) begin
      cell_column <= emit_pos.col;
      cell_row    <= emit_pos.row;
      glyph_code  <= op.glyph;
      cell_fg     <= op.fg;
      cell_bg     <= op.bg;
      out_last    <= emit_last;
    end
  end

endmodule
